// ===== rtl/centered_fir_convolution_assert.svh =====
// assertion macros shared by the centered fir convolution rtl
`ifndef CENTERED_FIR_CONVOLUTION_ASSERT_SVH
`define CENTERED_FIR_CONVOLUTION_ASSERT_SVH

// same-cycle implication
`define CFIR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFIR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cfir_pkg.sv =====
// types, constants and width helpers for the centered fir convolution
`timescale 1ns / 1ps

package cfir_pkg;

   localparam int MAX_TAPS     = 32;
   localparam int SAMPLE_WIDTH = 16;
   localparam int TAP_INDEX_W  = 5;
   localparam int TAP_COUNT_W  = 6;
   localparam int DELTA_W      = 16;
   localparam int DELTA_FRAC   = 12;
   localparam int SEEN_W       = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_TAP_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELTA_SCALE = 2'd1;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 6'd31;
   localparam logic [DELTA_W-1:0]     DELTA_RESET     = 16'd4096;

   typedef struct packed {
      logic                           cmd;
      logic [TAP_INDEX_W-1:0]         tap_index;
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic                           last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] result;
      logic                           saturated;
      logic                           end_of_spectrum;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic rotate;
      logic tap_wr;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_ALIGN,
      ST_ACCUM,
      ST_MUL,
      ST_SUM,
      ST_ROUND
   } state_type;

   function automatic int idx_w(int max_taps);
      return (max_taps > 1) ? $clog2(max_taps) : 1;
   endfunction

   function automatic int cnt_w(int max_taps);
      return $clog2(max_taps + 1);
   endfunction

   function automatic int acc_w(int max_taps);
      return 2 * SAMPLE_WIDTH + $clog2(max_taps) + 1;
   endfunction

endpackage

// ===== rtl/centered_fir_convolution.sv =====
// centered fir convolution: sequencer, cell chain, scaling and result register
// a sample that yields a result stalls further requests until the result register takes
// its result; taps are first rotated, step by step, when tap_count differs from the current
// tap alignment, then the partial sum walks the cell chain; loads and samples without a
// result do not stall the request port
// a last sample flushes its remaining results, one zero shifted in per result
// reset clears control state and the sample history at once; taps are undefined until loaded
`timescale 1ns / 1ps
`include "centered_fir_convolution_assert.svh"

module centered_fir_convolution #(
   parameter int MAX_TAPS = cfir_pkg::MAX_TAPS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cfir_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cfir_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cfir_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cfir_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int SW    = cfir_pkg::SAMPLE_WIDTH;
   localparam int IDX_W = cfir_pkg::idx_w(MAX_TAPS);
   localparam int CNT_W = cfir_pkg::cnt_w(MAX_TAPS);
   localparam int ACC_W = cfir_pkg::acc_w(MAX_TAPS);
   localparam int EW    = (CNT_W > cfir_pkg::SEEN_W) ? CNT_W : cfir_pkg::SEEN_W;
   localparam int AW    = ((IDX_W > cfir_pkg::TAP_INDEX_W) ? IDX_W : cfir_pkg::TAP_INDEX_W) + 1;

   cfir_pkg::state_type                 state_ff, state_in;
   logic                                flush_ff, flush_in;
   logic [CNT_W-1:0]                    step_ff, step_in;
   logic [CNT_W-1:0]                    lag_ff, lag_in;
   logic [CNT_W-1:0]                    skip_ff, skip_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [IDX_W-1:0]                    rot_ff, rot_in;
   logic [cfir_pkg::SEEN_W-1:0]         seen_ff, seen_in;
   logic [cfir_pkg::TAP_COUNT_W-1:0]    tap_count_ff, tap_count_in;
   logic [cfir_pkg::DELTA_W-1:0]        delta_ff, delta_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   cfir_pkg::rsp_type                   rsp_payload_ff, rsp_payload_in;

   logic                                req_ok, sample_ok, load_ok, csr_ok;
   logic                                out_free, load_out, is_end, emit_now;
   logic [EW-1:0]                       tc_ext, taps_ext, lag_ext, seen_ext, first_ext;
   logic [EW-1:0]                       skip_ext, off_ext;
   logic [IDX_W-1:0]                    offset;
   logic [CNT_W-1:0]                    step_next;
   logic [AW-1:0]                       idx_ext, addr_sum;
   logic [IDX_W-1:0]                    wr_addr;
   logic                                idx_in_range;
   logic signed [SW-1:0]                shift_value;
   cfir_pkg::cell_ctrl_type             ctrl;
   logic signed [SW-1:0]                scaled;
   logic                                scaled_sat;

   logic signed [SW-1:0]                hist_link [MAX_TAPS];
   logic signed [SW-1:0]                tap_link  [MAX_TAPS];
   logic signed [ACC_W-1:0]             acc_link  [MAX_TAPS];

   assign req_ok    = req_valid && !req_stall;
   assign sample_ok = req_ok && (req_payload.cmd == cfir_pkg::CMD_SAMPLE);
   assign load_ok   = req_ok && (req_payload.cmd == cfir_pkg::CMD_LOAD);
   assign csr_ready = 1'b1;
   assign csr_ok    = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_end    = flush_ff && (step_ff == lag_ff);
   assign step_next = step_ff + CNT_W'(1);

   // taps in use, lag and the tap rotation that lines the kernel up
   always_comb begin
      tc_ext = EW'(tap_count_ff);
      if (tc_ext == '0) begin
         taps_ext = EW'(1);
      end else if (tc_ext > EW'(MAX_TAPS)) begin
         taps_ext = EW'(MAX_TAPS);
      end else begin
         taps_ext = tc_ext;
      end
      lag_ext   = taps_ext - EW'(1) - (taps_ext >> 1);
      off_ext   = taps_ext - EW'(1);
      offset    = off_ext[IDX_W-1:0];
      seen_ext  = EW'(seen_ff);
      first_ext = (seen_ext < lag_ext) ? seen_ext : lag_ext;
      skip_ext  = lag_ext - first_ext;
      emit_now  = req_payload.last ? (skip_ext == '0) : (seen_ext >= lag_ext);
   end

   // tap load address follows the current rotation, kernel stored in reverse
   always_comb begin
      idx_ext      = AW'(req_payload.tap_index);
      idx_in_range = idx_ext < AW'(MAX_TAPS);
      addr_sum     = AW'(rot_ff) + AW'(MAX_TAPS) - idx_ext;
      if (addr_sum >= AW'(MAX_TAPS)) begin
         addr_sum = addr_sum - AW'(MAX_TAPS);
      end
      wr_addr = addr_sum[IDX_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfir_pkg::ST_IDLE: begin
            if (sample_ok) begin
               if (emit_now) begin
                  state_in = cfir_pkg::ST_ALIGN;
               end else if (req_payload.last) begin
                  state_in = cfir_pkg::ST_ZERO;
               end
            end
         end
         cfir_pkg::ST_ZERO: begin
            if (step_next >= skip_ff) begin
               state_in = cfir_pkg::ST_ALIGN;
            end
         end
         cfir_pkg::ST_ALIGN: begin
            if (rot_ff == offset) begin
               state_in = cfir_pkg::ST_ACCUM;
            end
         end
         cfir_pkg::ST_ACCUM: begin
            if (cnt_ff == CNT_W'(MAX_TAPS - 1)) begin
               state_in = cfir_pkg::ST_MUL;
            end
         end
         cfir_pkg::ST_MUL: state_in = cfir_pkg::ST_SUM;
         cfir_pkg::ST_SUM: state_in = cfir_pkg::ST_ROUND;
         cfir_pkg::ST_ROUND: begin
            if (out_free) begin
               state_in = (flush_ff && !is_end) ? cfir_pkg::ST_ZERO : cfir_pkg::ST_IDLE;
            end
         end
         default: state_in = cfir_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = (state_ff != cfir_pkg::ST_IDLE);
      shift_value = (state_ff == cfir_pkg::ST_IDLE) ? req_payload.value : '0;
      load_out    = (state_ff == cfir_pkg::ST_ROUND) && out_free;
      ctrl.shift  = ((state_ff == cfir_pkg::ST_IDLE) && sample_ok)
                 || (state_ff == cfir_pkg::ST_ZERO);
      ctrl.clear  = load_out && is_end;
      ctrl.rotate = (state_ff == cfir_pkg::ST_ALIGN) && (rot_ff != offset);
      ctrl.tap_wr = load_ok && idx_in_range;
   end

   // sequencing registers, configuration and result register
   always_comb begin
      flush_in       = flush_ff;
      step_in        = step_ff;
      lag_in         = lag_ff;
      skip_in        = skip_ff;
      seen_in        = seen_ff;
      cnt_in         = (state_ff == cfir_pkg::ST_ACCUM) ? cnt_ff + CNT_W'(1) : '0;
      rot_in         = rot_ff;
      tap_count_in   = tap_count_ff;
      delta_in       = delta_ff;
      rsp_valid_in   = load_out || (rsp_valid_ff && rsp_stall);
      rsp_payload_in = rsp_payload_ff;

      if (sample_ok) begin
         flush_in = req_payload.last;
         step_in  = '0;
         lag_in   = lag_ext[CNT_W-1:0];
         skip_in  = skip_ext[CNT_W-1:0];
         if (req_payload.last) begin
            seen_in = '0;
         end else if (seen_ff != cfir_pkg::SEEN_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
      end
      if (state_ff == cfir_pkg::ST_ZERO) begin
         step_in = step_next;
      end
      if (ctrl.rotate) begin
         rot_in = (rot_ff == IDX_W'(MAX_TAPS - 1)) ? '0 : rot_ff + IDX_W'(1);
      end
      if (load_out) begin
         rsp_payload_in.result          = scaled;
         rsp_payload_in.saturated       = scaled_sat;
         rsp_payload_in.end_of_spectrum = is_end;
         if (is_end) begin
            flush_in = 1'b0;
         end
      end
      if (csr_ok) begin
         unique case (csr_index)
            cfir_pkg::REG_TAP_COUNT:   tap_count_in = csr_data[cfir_pkg::TAP_COUNT_W-1:0];
            cfir_pkg::REG_DELTA_SCALE: delta_in     = csr_data[cfir_pkg::DELTA_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfir_pkg::ST_IDLE;
         flush_ff     <= 1'b0;
         step_ff      <= '0;
         lag_ff       <= '0;
         skip_ff      <= '0;
         cnt_ff       <= '0;
         rot_ff       <= '0;
         seen_ff      <= '0;
         tap_count_ff <= cfir_pkg::TAP_COUNT_RESET;
         delta_ff     <= cfir_pkg::DELTA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_ff     <= flush_in;
         step_ff      <= step_in;
         lag_ff       <= lag_in;
         skip_ff      <= skip_in;
         cnt_ff       <= cnt_in;
         rot_ff       <= rot_in;
         seen_ff      <= seen_in;
         tap_count_ff <= tap_count_in;
         delta_ff     <= delta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // cell chain: history shifts up, taps rotate up, partial sums walk up
   for (genvar m = 0; m < MAX_TAPS; m++) begin : g_cell
      logic signed [SW-1:0]    prev_hist;
      logic signed [ACC_W-1:0] prev_acc;
      if (m == 0) begin : g_head
         assign prev_hist = shift_value;
         assign prev_acc  = '0;
      end else begin : g_body
         assign prev_hist = hist_link[m-1];
         assign prev_acc  = acc_link[m-1];
      end
      cfir_cell #(
         .MAX_TAPS (MAX_TAPS),
         .INDEX    (m)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .wr_addr   (wr_addr),
         .offset    (offset),
         .wr_value  (req_payload.value),
         .prev_hist (prev_hist),
         .prev_tap  (tap_link[(m + MAX_TAPS - 1) % MAX_TAPS]),
         .prev_acc  (prev_acc),
         .hist_out  (hist_link[m]),
         .tap_out   (tap_link[m]),
         .acc_out   (acc_link[m])
      );
   end

   cfir_scale #(
      .MAX_TAPS (MAX_TAPS)
   ) u_scale (
      .clock     (clock),
      .acc       (acc_link[MAX_TAPS-1]),
      .delta     (delta_ff),
      .result    (scaled),
      .saturated (scaled_sat)
   );

   `CFIR_ASSERT_IMP(a_taps_aligned, clock, reset, state_ff == cfir_pkg::ST_ACCUM, rot_ff == offset, "taps not aligned during accumulation")
   `CFIR_ASSERT_IMP(a_step_bound, clock, reset, flush_ff, step_ff <= lag_ff, "flush step beyond lag")
   `CFIR_ASSERT_NEXT(a_end_clears, clock, reset, load_out && is_end, hist_link[0] == '0 && seen_ff == '0 && !flush_ff, "history not cleared after spectrum end")

endmodule

// ===== rtl/cfir_cell.sv =====
// one tap cell: history sample, rotating tap, product and partial sum
`timescale 1ns / 1ps

module cfir_cell #(
   parameter int MAX_TAPS = cfir_pkg::MAX_TAPS,
   parameter int INDEX    = 0
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  cfir_pkg::cell_ctrl_type                       ctrl,
   input  logic [cfir_pkg::idx_w(MAX_TAPS)-1:0]          wr_addr,
   input  logic [cfir_pkg::idx_w(MAX_TAPS)-1:0]          offset,
   input  logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]      wr_value,
   input  logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]      prev_hist,
   input  logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]      prev_tap,
   input  logic signed [cfir_pkg::acc_w(MAX_TAPS)-1:0]   prev_acc,
   output logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]      hist_out,
   output logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]      tap_out,
   output logic signed [cfir_pkg::acc_w(MAX_TAPS)-1:0]   acc_out
);

   localparam int SW     = cfir_pkg::SAMPLE_WIDTH;
   localparam int IDX_W  = cfir_pkg::idx_w(MAX_TAPS);
   localparam int ACC_W  = cfir_pkg::acc_w(MAX_TAPS);
   localparam int PROD_W = 2 * SW;
   localparam logic [IDX_W-1:0] CELL_ADDR = IDX_W'(INDEX);

   logic signed [SW-1:0]     hist_ff, hist_in;
   logic signed [SW-1:0]     tap_ff, tap_in;
   logic signed [PROD_W-1:0] prod_full;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   assign prod_full = tap_ff * hist_ff;

   always_comb begin
      hist_in = hist_ff;
      if (ctrl.clear) begin
         hist_in = '0;
      end else if (ctrl.shift) begin
         hist_in = prev_hist;
      end
      tap_in = tap_ff;
      if (ctrl.tap_wr && (wr_addr == CELL_ADDR)) begin
         tap_in = wr_value;
      end else if (ctrl.rotate) begin
         tap_in = prev_tap;
      end
      prod_in = (CELL_ADDR <= offset) ? prod_full : '0;
      acc_in  = prev_acc + $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign hist_out = hist_ff;
   assign tap_out  = tap_ff;
   assign acc_out  = acc_ff;

endmodule

// ===== rtl/cfir_scale.sv =====
// delta scaling in two partial products, round half up and saturate
`timescale 1ns / 1ps

module cfir_scale #(
   parameter int MAX_TAPS = cfir_pkg::MAX_TAPS
) (
   input  logic                                        clock,
   input  logic signed [cfir_pkg::acc_w(MAX_TAPS)-1:0] acc,
   input  logic [cfir_pkg::DELTA_W-1:0]                delta,
   output logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]    result,
   output logic                                        saturated
);

   localparam int SW    = cfir_pkg::SAMPLE_WIDTH;
   localparam int DW    = cfir_pkg::DELTA_W;
   localparam int ACC_W = cfir_pkg::acc_w(MAX_TAPS);
   localparam int LO_W  = ACC_W / 2;
   localparam int HI_W  = ACC_W - LO_W;
   localparam int PW    = ACC_W + DW + 1;
   localparam int RW    = PW + 1;
   localparam int SH    = SW - 1 + cfir_pkg::DELTA_FRAC;
   localparam int VW    = RW - SH;
   localparam logic [RW-1:0] HALF = RW'(1) << (SH - 1);
   localparam logic signed [VW-1:0] POS_LIMIT = {{(VW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [VW-1:0] NEG_LIMIT = {{(VW-SW+1){1'b1}}, {(SW-1){1'b0}}};

   logic [LO_W+DW-1:0]          p_lo_ff, p_lo_in;
   logic signed [HI_W+DW:0]     p_hi_ff, p_hi_in;
   logic signed [PW-1:0]        sum_ff, sum_in;
   logic signed [HI_W-1:0]      acc_hi;
   logic signed [DW:0]          delta_s;
   logic signed [RW-1:0]        rounded;
   logic signed [VW-1:0]        floored;

   always_comb begin
      acc_hi  = $signed(acc[ACC_W-1:LO_W]);
      delta_s = $signed({1'b0, delta});
      p_lo_in = acc[LO_W-1:0] * delta;
      p_hi_in = acc_hi * delta_s;
      sum_in  = $signed({p_hi_ff, {LO_W{1'b0}}})
              + $signed({{(PW-LO_W-DW){1'b0}}, p_lo_ff});
   end

   always_ff @(posedge clock) begin
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      sum_ff  <= sum_in;
   end

   always_comb begin
      rounded = $signed({sum_ff[PW-1], sum_ff}) + $signed(HALF);
      floored = $signed(rounded[RW-1:SH]);
      if (floored > POS_LIMIT) begin
         result    = POS_LIMIT[SW-1:0];
         saturated = 1'b1;
      end else if (floored < NEG_LIMIT) begin
         result    = NEG_LIMIT[SW-1:0];
         saturated = 1'b1;
      end else begin
         result    = floored[SW-1:0];
         saturated = 1'b0;
      end
   end

endmodule
